[src/ttlb_pkg.sv]
// Shared constants, transaction types and helper functions for the terminal line buffer.
package ttlb_pkg;

  localparam int STORED_LINES   = 32;
  localparam int CHARS_PER_LINE = 21;
  localparam int VIEW_LINES     = 10;

  localparam int LINE_W  = $clog2(STORED_LINES);
  localparam int COL_W   = $clog2(CHARS_PER_LINE + 1);
  localparam int CELLS   = STORED_LINES * CHARS_PER_LINE;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int RSUM_W  = ((LINE_W > 4) ? LINE_W : 4) + 1;

  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_BEL = 8'h07;
  localparam logic [7:0] CHAR_BS  = 8'h08;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_DRAW   = 3'd1,
    KIND_REDRAW = 3'd2,
    KIND_BELL   = 3'd3,
    KIND_READ   = 3'd4
  } kind_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] byte_in;
    logic [3:0] read_row;
    logic [4:0] read_col;
  } in_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] glyph;
    logic [4:0] column;
    logic [3:0] row;
    logic [4:0] view_top;
    logic       cell_empty;
  } out_item_t;

  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wr_data;
  } cell_req_t;

  // Ring addition of two line numbers, each below STORED_LINES.
  function automatic logic [LINE_W-1:0] ring_add(logic [LINE_W:0] a, logic [LINE_W:0] b);
    logic [LINE_W+1:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (LINE_W+2)'(STORED_LINES)) begin
      s = s - (LINE_W+2)'(STORED_LINES);
    end
    return s[LINE_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(logic [LINE_W-1:0] line,
                                                  logic [COL_W-1:0] col);
    logic [ADDR_W+LINE_W+COL_W-1:0] a;
    a = (ADDR_W+LINE_W+COL_W)'(line) * (ADDR_W+LINE_W+COL_W)'(CHARS_PER_LINE)
        + (ADDR_W+LINE_W+COL_W)'(col);
    return a[ADDR_W-1:0];
  endfunction

endpackage

[src/ttlb_cells.sv]
// Text cell store: one write or one registered read per cycle.
module ttlb_cells (
  input  logic                clk,
  input  ttlb_pkg::cell_req_t req,
  output logic [7:0]          rd_data
);
  import ttlb_pkg::*;

  logic [7:0] mem [CELLS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.addr];
    end
  end

endmodule

[src/ttlb_ctrl.sv]
// Cursor, view top and line length state with the per-byte decision logic.
module ttlb_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  ttlb_pkg::in_item_t   item,
  output ttlb_pkg::cell_req_t  req,
  output ttlb_pkg::out_item_t  result
);
  import ttlb_pkg::*;

  logic [LINE_W-1:0] cur_line, cur_line_next;
  logic [COL_W-1:0]  cur_col, cur_col_next;
  logic [LINE_W-1:0] base, base_next;
  logic [LINE_W-1:0] vt, vt_next;

  // Two identical copies: one is looked up at the cursor line, the other at the read line.
  logic [COL_W-1:0]  len_cur [STORED_LINES];
  logic [COL_W-1:0]  len_rd  [STORED_LINES];

  logic              len_we;
  logic [LINE_W-1:0] len_wa;
  logic [COL_W-1:0]  len_wd;

  logic [LINE_W-1:0] phys_cur, phys_nxt, wphys, ln, target, rphys;
  logic [COL_W-1:0]  len_here, wcol, wlen, rlen;
  logic              at_last, wrap, redraw, in_range, empty;
  logic [RSUM_W-1:0] rsum;

  always_comb begin
    phys_cur = ring_add({1'b0, cur_line}, {1'b0, base});
    phys_nxt = ring_add({1'b0, phys_cur}, (LINE_W+1)'(1));
    at_last  = (cur_line == LINE_W'(STORED_LINES - 1));
    len_here = len_cur[phys_cur];
    wrap     = (cur_col >= COL_W'(CHARS_PER_LINE));

    // A write past the line end moves to a new line first; on the last line the
    // ring base steps and the freed slot becomes the new last line.
    ln    = (wrap && !at_last) ? cur_line + LINE_W'(1) : cur_line;
    wphys = wrap ? phys_nxt : phys_cur;
    wcol  = wrap ? '0 : cur_col;
    wlen  = wrap ? '0 : len_here;
    if (int'(ln) >= VIEW_LINES - 1) begin
      target = ln - LINE_W'(VIEW_LINES - 1);
    end else begin
      target = '0;
    end
    redraw = (wrap && at_last) || (target != vt);

    rsum     = RSUM_W'(vt) + RSUM_W'(item.read_row);
    in_range = (int'(item.read_row) < VIEW_LINES) && (rsum < RSUM_W'(STORED_LINES))
               && (int'(item.read_col) < CHARS_PER_LINE);
    rphys    = ring_add((LINE_W+1)'(rsum), {1'b0, base});
    rlen     = len_rd[rphys];
    empty    = !(in_range && ((COL_W+5)'(item.read_col) < (COL_W+5)'(rlen)));

    cur_line_next = cur_line;
    cur_col_next  = cur_col;
    base_next     = base;
    vt_next       = vt;
    len_we        = 1'b0;
    len_wa        = wphys;
    len_wd        = '0;
    req           = '0;
    result        = '0;
    result.kind   = KIND_NONE;

    if (item.mode == MODE_READ) begin
      req.rd_en         = accept && !empty;
      req.addr          = cell_addr(rphys, COL_W'(item.read_col));
      result.kind       = KIND_READ;
      result.column     = item.read_col;
      result.row        = item.read_row;
      result.cell_empty = empty;
    end else begin
      case (item.byte_in)
        CHAR_CR: begin
          cur_col_next = '0;
        end
        CHAR_LF: begin
          cur_col_next = '0;
          len_we       = 1'b1;
          len_wa       = phys_nxt;
          if (at_last) begin
            base_next   = ring_add({1'b0, base}, (LINE_W+1)'(1));
            result.kind = KIND_REDRAW;
          end else begin
            cur_line_next = cur_line + LINE_W'(1);
          end
        end
        CHAR_BEL: begin
          result.kind = KIND_BELL;
        end
        CHAR_BS: begin
          if (cur_col == '0) begin
            if (cur_line != '0) begin
              cur_line_next = cur_line - LINE_W'(1);
              cur_col_next  = COL_W'(CHARS_PER_LINE - 1);
            end
          end else begin
            cur_col_next = cur_col - COL_W'(1);
          end
        end
        default: begin
          if (wrap && at_last) begin
            base_next = ring_add({1'b0, base}, (LINE_W+1)'(1));
          end
          cur_line_next = ln;
          cur_col_next  = wcol + COL_W'(1);
          vt_next       = target;
          len_we        = 1'b1;
          len_wa        = wphys;
          len_wd        = (wcol == wlen) ? wcol + COL_W'(1) : wlen;
          req.wr_en     = accept;
          req.addr      = cell_addr(wphys, wcol);
          req.wr_data   = item.byte_in;
          if (redraw) begin
            result.kind = KIND_REDRAW;
          end else begin
            result.kind   = KIND_DRAW;
            result.glyph  = item.byte_in;
            result.column = 5'(wcol);
            result.row    = 4'(ln - vt);
          end
        end
      endcase
    end
    result.view_top = 5'(vt_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_line <= '0;
      cur_col  <= '0;
      base     <= '0;
      vt       <= '0;
      for (int i = 0; i < STORED_LINES; i++) begin
        len_cur[i] <= '0;
        len_rd[i]  <= '0;
      end
    end else if (accept) begin
      cur_line <= cur_line_next;
      cur_col  <= cur_col_next;
      base     <= base_next;
      vt       <= vt_next;
      if (len_we) begin
        len_cur[len_wa] <= len_wd;
        len_rd[len_wa]  <= len_wd;
      end
    end
  end

endmodule

[src/text_terminal_line_buffer.sv]
// Terminal line buffer: one transaction per cycle in unless the output stalls; the
// registered result appears in the cycle after acceptance.
// Throughput is one item per cycle; the result register and the registered read
// of the text cell memory advance together and hold while the output stalls.
// Reset clears the cursor, view top, ring base, all line lengths and output valid;
// the text cell memory is not cleared, since reads are gated by line length.
module text_terminal_line_buffer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ttlb_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ttlb_pkg::out_item_t out_data
);
  import ttlb_pkg::*;

  logic      accept;
  cell_req_t req;
  out_item_t result;
  out_item_t res;
  logic [7:0] cell_q;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  ttlb_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (in_data),
    .req    (req),
    .result (result)
  );

  ttlb_cells u_cells (
    .clk     (clk),
    .req     (req),
    .rd_data (cell_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (accept) begin
      res <= result;
    end
  end

  // A visible read takes its glyph from the memory read that ran alongside the result.
  always_comb begin
    out_data = res;
    if (res.kind == KIND_READ && !res.cell_empty) begin
      out_data.glyph = cell_q;
    end
  end

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted transaction produced no result");

  a_empty_is_read: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.cell_empty) |->
      (out_data.kind == KIND_READ && out_data.glyph == 8'd0))
    else $error("empty cell flag on a non-read result or with a glyph");

  a_draw_row_in_view: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.kind == KIND_DRAW) |-> (int'(out_data.row) < VIEW_LINES))
    else $error("cell draw outside the view");

endmodule
